### src/rpc_pkg.sv
// Package for the rectangular/polar converter: datapath widths, the
// arctangent table and the beat types shared by the cell row and gain stage.
// No dependencies.
`default_nettype none

package rpc_pkg;

  // Number of micro-rotations; the table bounds the usable depth
  localparam int ITERATIONS = 16;
  localparam int TABLE_LEN  = 24;
  localparam int N_CELLS    = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

  // Field widths
  localparam int CW  = 18;  // Q9.8 coordinate
  localparam int AW  = 16;  // binary angle
  localparam int RW  = 19;  // radius result
  // Datapath widths: coordinates carry 8 extra fraction bits plus growth
  localparam int XW  = 28;
  localparam int ZW  = 34;  // angle accumulator, 2^31 is a half turn
  localparam int SW  = $clog2(TABLE_LEN);

  // Gain removal: 1/K in Q0.30, rounded by 2^37, shifted by 38
  localparam int GW       = 31;
  localparam int PW       = XW + GW;
  localparam int GSHIFT   = 38;
  localparam int QW       = PW - GSHIFT;
  localparam logic signed [GW-1:0] INV_GAIN = GW'(652032874);
  localparam logic signed [PW-1:0] GROUND   = PW'(1) <<< (GSHIFT - 1);

  localparam logic signed [ZW-1:0] HALF_TURN   = ZW'(1) <<< 31;
  localparam logic signed [ZW-1:0] ANG_ROUND   = ZW'(32768);
  localparam logic signed [AW-1:0] QUARTER_BIN = AW'(16384);
  localparam logic signed [AW-1:0] ANG_NEG_PI  = {1'b1, {(AW-1){1'b0}}};

  localparam logic signed [CW-1:0] XY_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] XY_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [RW-1:0] RAD_MAX = {1'b0, {(RW-1){1'b1}}};

  // atan(2^-i) / pi * 2^31, rounded to nearest
  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic {
    OP_TO_POLAR = 1'b0,
    OP_TO_RECT  = 1'b1
  } op_t;

  // Input fields carried alongside the rotation
  typedef struct packed {
    op_t                   op;
    logic                  axis;   // to-polar point on the x axis
    logic signed [CW-1:0]  xi;
    logic signed [CW-1:0]  yi;
    logic signed [CW-1:0]  ri;
    logic signed [AW-1:0]  ai;
  } side_t;

  typedef struct packed {
    side_t                 side;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [ZW-1:0]  z;
  } cord_t;

endpackage

`default_nettype wire

### src/rect_polar_converter.sv
// Top level of the rectangular/polar converter: input pre-turn, a row of
// CORDIC cells and the gain/format stage. Uses rpc_pkg, rpc_cell, rpc_gain.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_ready  | op, x_in, y_in, radius_in, angle_in
//   out     | out_valid/out_ready| x_out, y_out, radius_out, angle_out
//
// One beat enters per cycle while the row is not stalled; each result passes
// through one register per cell, then the 1/K multipliers and the rounding
// into the output register.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output freezes the whole row; in_ready follows out_ready while
// the output register is full.
`default_nettype none

module rect_polar_converter (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     op,
  input  wire logic signed [rpc_pkg::CW-1:0] x_in,
  input  wire logic signed [rpc_pkg::CW-1:0] y_in,
  input  wire logic signed [rpc_pkg::CW-1:0] radius_in,
  input  wire logic signed [rpc_pkg::AW-1:0] angle_in,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [rpc_pkg::CW-1:0] x_out,
  output logic signed [rpc_pkg::CW-1:0] y_out,
  output logic signed [rpc_pkg::RW-1:0] radius_out,
  output logic signed [rpc_pkg::AW-1:0] angle_out
);
  import rpc_pkg::*;

  logic   en;
  logic   chain_vld [N_CELLS+1];
  cord_t  chain     [N_CELLS+1];
  cord_t  prep;
  logic signed [XW-1:0] xs_in;
  logic signed [XW-1:0] ys_in;
  logic signed [XW-1:0] rs_in;

  // Advance the whole row unless the output register is full and held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Scale the inputs and turn them into the right half plane
  always_comb begin
    xs_in = XW'(x_in) <<< 8;
    ys_in = XW'(y_in) <<< 8;
    rs_in = XW'(radius_in) <<< 8;
    prep.side.op   = op_t'(op);
    prep.side.axis = (y_in == '0);
    prep.side.xi   = x_in;
    prep.side.yi   = y_in;
    prep.side.ri   = radius_in;
    prep.side.ai   = angle_in;
    if (op_t'(op) == OP_TO_POLAR) begin
      if (x_in[CW-1]) begin
        prep.x = -xs_in;
        prep.y = -ys_in;
        prep.z = HALF_TURN;
      end else begin
        prep.x = xs_in;
        prep.y = ys_in;
        prep.z = '0;
      end
    end else begin
      prep.y = '0;
      prep.z = ZW'(angle_in) <<< 16;
      if (angle_in > QUARTER_BIN) begin
        prep.x = -rs_in;
        prep.z = (ZW'(angle_in) <<< 16) - HALF_TURN;
      end else if (angle_in < -QUARTER_BIN) begin
        prep.x = -rs_in;
        prep.z = (ZW'(angle_in) <<< 16) + HALF_TURN;
      end else begin
        prep.x = rs_in;
      end
    end
  end

  assign chain_vld[0] = in_valid;
  assign chain[0]     = prep;

  // Row of micro-rotation cells
  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    rpc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .step    (SW'(g)),
      .vld_in  (chain_vld[g]),
      .cin     (chain[g]),
      .vld_out (chain_vld[g+1]),
      .cout    (chain[g+1])
    );
  end

  rpc_gain u_gain (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .vld_in     (chain_vld[N_CELLS]),
    .cin        (chain[N_CELLS]),
    .vld_out    (out_valid),
    .x_out      (x_out),
    .y_out      (y_out),
    .radius_out (radius_out),
    .angle_out  (angle_out)
  );

  // Reset leaves the row empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !chain_vld[1] && !out_valid)
    else $error("pipeline not empty after reset");

  // Vectoring keeps x nonnegative at the end of the row
  a_vec_x_pos: assert property (@(posedge clk) disable iff (rst)
    chain_vld[N_CELLS] && chain[N_CELLS].side.op == OP_TO_POLAR
      |-> !chain[N_CELLS].x[XW-1])
    else $error("vectoring produced a negative x");

  // A stall holds the last cell
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en && chain_vld[N_CELLS] |=> chain_vld[N_CELLS] && $stable(chain[N_CELLS]))
    else $error("last cell changed while stalled");

endmodule

`default_nettype wire

### src/rpc_cell.sv
// One CORDIC micro-rotation cell: vectoring for to-polar beats, rotation for
// to-rect beats. Shift amount and table entry follow from the step port,
// which the top level ties to the cell's place in the row. Uses rpc_pkg.
`default_nettype none

module rpc_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic [rpc_pkg::SW-1:0] step,
  input  wire logic               vld_in,
  input  wire rpc_pkg::cord_t     cin,
  output logic                    vld_out,
  output rpc_pkg::cord_t          cout
);
  import rpc_pkg::*;

  logic                  ccw;
  logic signed [XW-1:0]  xs;
  logic signed [XW-1:0]  ys;
  logic signed [ZW-1:0]  az;
  cord_t                 cnext;

  // Pick the turn direction and apply one shift-add step
  always_comb begin
    if (cin.side.op == OP_TO_RECT) begin
      ccw = !cin.z[ZW-1];
    end else begin
      ccw = cin.y[XW-1];
    end
    xs = cin.x >>> step;
    ys = cin.y >>> step;
    az = ZW'(ATAN_TAB[step]);
    cnext      = cin;
    if (ccw) begin
      cnext.x = cin.x - ys;
      cnext.y = cin.y + xs;
      cnext.z = cin.z - az;
    end else begin
      cnext.x = cin.x + ys;
      cnext.y = cin.y - xs;
      cnext.z = cin.z + az;
    end
  end

  // Hand the beat to the neighbor when the row advances
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= cnext;
    end
  end

endmodule

`default_nettype wire

### src/rpc_gain.sv
// Gain removal and result formatting: multiply by 1/K, then round, clamp and
// select the pass-through fields into the output register. Uses rpc_pkg.
`default_nettype none

module rpc_gain (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               vld_in,
  input  wire rpc_pkg::cord_t     cin,
  output logic                    vld_out,
  output logic signed [rpc_pkg::CW-1:0] x_out,
  output logic signed [rpc_pkg::CW-1:0] y_out,
  output logic signed [rpc_pkg::RW-1:0] radius_out,
  output logic signed [rpc_pkg::AW-1:0] angle_out
);
  import rpc_pkg::*;

  logic                  vld_p;
  side_t                 side_p;
  logic signed [PW-1:0]  px;
  logic signed [PW-1:0]  py;
  logic signed [ZW-1:0]  zr;

  logic signed [PW-1:0]  sx;
  logic signed [PW-1:0]  sy;
  logic signed [QW-1:0]  qx;
  logic signed [QW-1:0]  qy;
  logic signed [CW-1:0]  x_next;
  logic signed [CW-1:0]  y_next;
  logic signed [RW-1:0]  radius_next;
  logic signed [AW-1:0]  angle_next;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else if (en) begin
      vld_p <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_p <= cin.side;
      px     <= PW'(cin.x) * PW'(INV_GAIN);
      py     <= PW'(cin.y) * PW'(INV_GAIN);
      zr     <= cin.z + ANG_ROUND;
    end
  end

  // Round half up, clamp and pick the computed or passed pair
  always_comb begin
    sx = (px + GROUND) >>> GSHIFT;
    sy = (py + GROUND) >>> GSHIFT;
    qx = sx[QW-1:0];
    qy = sy[QW-1:0];
    if (side_p.op == OP_TO_RECT) begin
      if (qx > QW'(XY_MAX)) begin
        x_next = XY_MAX;
      end else if (qx < QW'(XY_MIN)) begin
        x_next = XY_MIN;
      end else begin
        x_next = qx[CW-1:0];
      end
      if (qy > QW'(XY_MAX)) begin
        y_next = XY_MAX;
      end else if (qy < QW'(XY_MIN)) begin
        y_next = XY_MIN;
      end else begin
        y_next = qy[CW-1:0];
      end
      radius_next = RW'(side_p.ri);
      angle_next  = side_p.ai;
    end else begin
      x_next = side_p.xi;
      y_next = side_p.yi;
      if (side_p.axis) begin
        // Point on the x axis: exact magnitude, angle zero or minus pi
        if (side_p.xi[CW-1]) begin
          radius_next = -RW'(side_p.xi);
          angle_next  = ANG_NEG_PI;
        end else begin
          radius_next = RW'(side_p.xi);
          angle_next  = '0;
        end
      end else begin
        if (qx < 0) begin
          radius_next = '0;
        end else if (qx > QW'(RAD_MAX)) begin
          radius_next = RAD_MAX;
        end else begin
          radius_next = qx[RW-1:0];
        end
        angle_next = zr[31:16];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out      <= x_next;
      y_out      <= y_next;
      radius_out <= radius_next;
      angle_out  <= angle_next;
    end
  end

  // A held stage keeps its valid bits
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld_p) && $stable(vld_out))
    else $error("gain stage valid changed while stalled");

endmodule

`default_nettype wire
